[rtl/probe_request_ie_fingerprint_defines.svh]
// Assertion macros shared by the probe-request fingerprint RTL.
`ifndef PROBE_REQUEST_IE_FINGERPRINT_DEFINES_SVH
`define PROBE_REQUEST_IE_FINGERPRINT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PIEFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("piefp: implication check failed");

// Next-cycle implication, disabled during reset.
`define PIEFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("piefp: next-cycle check failed");

`endif

[rtl/piefp_pkg.sv]
// Types, constants and hash helper for the probe-request fingerprint block.
package piefp_pkg;

  localparam logic [11:0] MAX_FRAME_LENGTH = 12'd4095;
  localparam logic [7:0]  MAX_SSID_LENGTH  = 8'd32;
  localparam logic [31:0] HASH_BASIS       = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME       = 32'd16777619;
  localparam logic [7:0]  MGMT_PROBE_FC    = 8'h40;
  localparam logic [7:0]  ID_SSID          = 8'h00;
  localparam logic [7:0]  ID_DS_PARAM      = 8'h03;
  localparam logic [11:0] HEADER_BYTES     = 12'd24;
  localparam logic [11:0] HDR_PLUS_FCS     = 12'd28;
  localparam logic [11:0] MIN_FRAME_LENGTH = 12'd30;

  localparam logic KIND_SSID_BYTE = 1'b0;
  localparam logic KIND_RECORD    = 1'b1;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [11:0] frame_length;
    logic        is_management;
    logic        last_byte;
  } piefp_item_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  ssid_byte;
    logic [31:0] fingerprint;
    logic [5:0]  ssid_length;
    logic        ssid_present;
  } piefp_result_t;

  // One FNV-1a step: xor in a byte, multiply by the prime (mod 2^32).
  function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] v);
    logic [31:0] x;
    x = h ^ {24'd0, v};
    return x * HASH_PRIME;
  endfunction

endpackage

[rtl/piefp_walker.sv]
// Per-frame element walker: acceptance, header hash, SSID tracking, result build.
module piefp_walker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  piefp_pkg::piefp_item_t   item,
  input  logic                     capture_enabled,
  output logic                     res_valid,
  output piefp_pkg::piefp_result_t res
);

  typedef enum logic [2:0] {
    PH_ID   = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    SR_SEARCH = 3'b001,
    SR_STREAM = 3'b010,
    SR_DONE   = 3'b100
  } search_t;

  logic [11:0] byte_position, byte_position_next;
  logic        frame_accepted, frame_accepted_next;
  phase_t      element_phase, element_phase_next;
  logic [7:0]  body_remaining, body_remaining_next;
  logic [7:0]  current_element_id, current_element_id_next;
  logic [31:0] running_hash, running_hash_next;
  logic [31:0] pre_hash, pre_hash_next;
  search_t     ssid_search_state, ssid_search_state_next;
  logic [5:0]  found_ssid_length, found_ssid_length_next;
  logic        walk_ended, walk_ended_next;

  logic [11:0] rel;
  logic [11:0] area;
  logic        fits;
  logic        ssid_out;
  logic [7:0]  b;

  assign b    = item.byte_value;
  assign rel  = byte_position - piefp_pkg::HEADER_BYTES;
  assign area = (item.frame_length >= piefp_pkg::HDR_PLUS_FCS) ?
                item.frame_length - piefp_pkg::HDR_PLUS_FCS : 12'd0;
  assign fits = ({1'b0, rel} + 13'd1 + {5'd0, b}) <= {1'b0, area};

  always_comb begin
    byte_position_next      = byte_position;
    frame_accepted_next     = frame_accepted;
    element_phase_next      = element_phase;
    body_remaining_next     = body_remaining;
    current_element_id_next = current_element_id;
    running_hash_next       = running_hash;
    pre_hash_next           = pre_hash;
    ssid_search_state_next  = ssid_search_state;
    found_ssid_length_next  = found_ssid_length;
    walk_ended_next         = walk_ended;
    ssid_out                = 1'b0;

    // Rest of the state already holds start values on the first byte.
    if (byte_position == 12'd0) begin
      frame_accepted_next = capture_enabled && item.is_management &&
                            (b == piefp_pkg::MGMT_PROBE_FC) &&
                            (item.frame_length >= piefp_pkg::MIN_FRAME_LENGTH);
    end

    if (frame_accepted && (byte_position >= piefp_pkg::HEADER_BYTES) && !walk_ended) begin
      if (rel >= area) begin
        walk_ended_next = 1'b1;
      end else begin
        unique case (element_phase)
          PH_ID: begin
            current_element_id_next = b;
            pre_hash_next           = piefp_pkg::fnv_fold(running_hash, b);
            element_phase_next      = PH_LEN;
          end
          PH_LEN: begin
            if (current_element_id != piefp_pkg::ID_SSID &&
                current_element_id != piefp_pkg::ID_DS_PARAM) begin
              running_hash_next = piefp_pkg::fnv_fold(pre_hash, b);
            end
            if (ssid_search_state == SR_SEARCH && current_element_id == piefp_pkg::ID_SSID) begin
              if (b != 8'd0 && b <= piefp_pkg::MAX_SSID_LENGTH && fits) begin
                found_ssid_length_next = b[5:0];
                ssid_search_state_next = SR_STREAM;
              end else begin
                found_ssid_length_next = 6'd0;
                ssid_search_state_next = SR_DONE;
              end
            end
            body_remaining_next = b;
            element_phase_next  = (b != 8'd0) ? PH_BODY : PH_ID;
          end
          PH_BODY: begin
            ssid_out = (ssid_search_state == SR_STREAM);
            if (body_remaining <= 8'd1) begin
              body_remaining_next = 8'd0;
              element_phase_next  = PH_ID;
              if (ssid_search_state == SR_STREAM) ssid_search_state_next = SR_DONE;
            end else begin
              body_remaining_next = body_remaining - 8'd1;
            end
          end
          default: element_phase_next = PH_ID;
        endcase
      end
    end

    res_valid        = 1'b0;
    res.record_kind  = piefp_pkg::KIND_SSID_BYTE;
    res.ssid_byte    = b;
    res.fingerprint  = 32'd0;
    res.ssid_length  = found_ssid_length_next;
    res.ssid_present = 1'b1;

    if (item.last_byte) begin
      res_valid        = frame_accepted_next;
      res.record_kind  = piefp_pkg::KIND_RECORD;
      res.ssid_byte    = 8'd0;
      res.fingerprint  = running_hash_next;
      res.ssid_present = (found_ssid_length_next != 6'd0);
      // Back to frame start for the next item.
      byte_position_next      = 12'd0;
      frame_accepted_next     = 1'b0;
      element_phase_next      = PH_ID;
      body_remaining_next     = 8'd0;
      current_element_id_next = 8'd0;
      running_hash_next       = piefp_pkg::HASH_BASIS;
      ssid_search_state_next  = SR_SEARCH;
      found_ssid_length_next  = 6'd0;
      walk_ended_next         = 1'b0;
    end else begin
      res_valid = ssid_out;
      if (byte_position < piefp_pkg::MAX_FRAME_LENGTH) byte_position_next = byte_position + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= 12'd0;
      frame_accepted     <= 1'b0;
      element_phase      <= PH_ID;
      body_remaining     <= 8'd0;
      current_element_id <= 8'd0;
      running_hash       <= piefp_pkg::HASH_BASIS;
      ssid_search_state  <= SR_SEARCH;
      found_ssid_length  <= 6'd0;
      walk_ended         <= 1'b0;
    end else if (advance) begin
      byte_position      <= byte_position_next;
      frame_accepted     <= frame_accepted_next;
      element_phase      <= element_phase_next;
      body_remaining     <= body_remaining_next;
      current_element_id <= current_element_id_next;
      running_hash       <= running_hash_next;
      ssid_search_state  <= ssid_search_state_next;
      found_ssid_length  <= found_ssid_length_next;
      walk_ended         <= walk_ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) pre_hash <= pre_hash_next;
  end

endmodule

[rtl/probe_request_ie_fingerprint.sv]
// Top level of the probe-request element fingerprint block.
//
// Usage:
//   Input channel (in_valid/in_ready): one frame byte per item, with the
//   frame length, management flag and last_byte marker. Output channel
//   (out_valid/out_ready): an SSID byte (record_kind 0) or the end-of-frame
//   fingerprint record (record_kind 1). Items that produce nothing are
//   absorbed silently.
//   Config: cfg_write_en/cfg_write_data set capture_enabled; write it only
//   while the block is idle. It is sampled on the first byte of each frame.
// Timing:
//   One item per cycle sustained while out_ready stays high. An accepted
//   item is held in the input register, where the walker evaluates it and
//   updates the frame state, and its result is then loaded into the output
//   register, from which it leaves when out_ready is high. The hash step is
//   one constant multiply per cycle while the walker advances; the two folds
//   of an element header are split across its id and length bytes.
// Reset: rst (sync, active high) clears both stages, the frame state and
//   capture_enabled; the hash reloads to the FNV offset basis.
// Stall: while out_ready is low with a result pending, the input register
//   holds its item and in_ready drops once that register is full.
`include "probe_request_ie_fingerprint_defines.svh"

module probe_request_ie_fingerprint (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic [11:0] frame_length,
  input  logic        is_management,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        record_kind,
  output logic [7:0]  ssid_byte,
  output logic [31:0] fingerprint,
  output logic [5:0]  ssid_length,
  output logic        ssid_present
);

  logic                     capture_enabled;
  logic                     s1_valid;
  piefp_pkg::piefp_item_t   s1_item;
  logic                     s1_take;
  logic                     advance;
  logic                     res_valid;
  piefp_pkg::piefp_result_t res;
  piefp_pkg::piefp_result_t out_rec;

  // Output stage can take a new result when empty or draining.
  assign s1_take  = !out_valid || out_ready;
  assign advance  = s1_valid && s1_take;
  assign in_ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enabled <= 1'b0;
    end else if (cfg_write_en) begin
      capture_enabled <= cfg_write_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item.byte_value    <= byte_value;
      s1_item.frame_length  <= frame_length;
      s1_item.is_management <= is_management;
      s1_item.last_byte     <= last_byte;
    end
  end

  piefp_walker u_walker (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .item            (s1_item),
    .capture_enabled (capture_enabled),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= s1_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) out_rec <= res;
  end

  assign record_kind  = out_rec.record_kind;
  assign ssid_byte    = out_rec.ssid_byte;
  assign fingerprint  = out_rec.fingerprint;
  assign ssid_length  = out_rec.ssid_length;
  assign ssid_present = out_rec.ssid_present;

  // An SSID byte is only streamed for a found, nonzero-length SSID.
  `PIEFP_ASSERT_IMPL(a_ssid_byte_has_len, clk, rst,
    out_valid && record_kind == piefp_pkg::KIND_SSID_BYTE,
    ssid_present && ssid_length != 6'd0 && fingerprint == 32'd0)
  // Presence flag agrees with the reported length on every record.
  `PIEFP_ASSERT_IMPL(a_present_matches_len, clk, rst,
    out_valid && record_kind == piefp_pkg::KIND_RECORD,
    ssid_present == (ssid_length != 6'd0) && ssid_byte == 8'd0)
  // Input stage must hold its item while the result register is stalled.
  `PIEFP_ASSERT_NEXT(a_stall_holds_s1, clk, rst,
    s1_valid && out_valid && !out_ready,
    s1_valid && $stable(s1_item))

endmodule
